// ===== rtl/core/dlt698_link_frame_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Link frame detector assertion macros
// Shared helpers for writing concurrent checks on the clk/arst_n domain.
// ----------------------------------------------------------------------------
`ifndef DLT698_LINK_FRAME_DETECTOR_DEFINES_SVH
`define DLT698_LINK_FRAME_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DLT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dlt_pkg.sv =====
// ----------------------------------------------------------------------------
// Link frame detector package
// Widths, byte codes, register indexes, drop codes and the result record.
// ----------------------------------------------------------------------------
package dlt_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int BUFFER_SLACK    = 20;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES);

	localparam logic [POS_W-1:0] LIMIT_CAP = POS_W'(MAX_FRAME_BYTES - BUFFER_SLACK);

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE   = 8'h16;

	localparam logic [7:0]  TIMEOUT_RESET = 8'd5;
	localparam logic [15:0] LIMIT_RESET   = 16'd2028;
	localparam logic [7:0]  TICKS_MAX     = 8'hff;

	typedef enum logic [0:0] {
		REG_TIMEOUT = 1'b0,
		REG_LIMIT   = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		DROP_NONE      = 3'd0,
		DROP_TOO_LONG  = 3'd1,
		DROP_BAD_END   = 3'd2,
		DROP_TIMEOUT   = 3'd3,
		DROP_TOO_SHORT = 3'd4
	} drop_t;

	typedef struct packed {
		logic [7:0]       byte_out;
		logic [POS_W-1:0] byte_index;
		logic             byte_kept;
		logic             frame_start;
		logic             frame_complete;
		logic [POS_W-1:0] frame_length;
		drop_t            drop_code;
	} result_t;

endpackage

// ===== rtl/core/dlt698_link_frame_detector.sv =====
// ----------------------------------------------------------------------------
// DL/T 698.45 link frame detector
// Finds link frames in a received byte stream and tags each byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one request per byte or tick:
// op selects a received byte or a one-second tick, data_byte holds the byte.
// Output channel (out_valid/out_stall) returns at most one result per request:
// every byte gives one, a tick gives one only when it times out a frame.
// Requests are taken into an input register; the frame state machine handles
// the registered request and writes the result register in the same cycle.
// A request passes the input register and then the result register before its
// result shows on out_valid. Throughput is one request per cycle while the
// receiver does not stall, as the parser updates its frame state per request.
// When the receiver stalls, the result register holds its payload, the input
// register fills, and in_stall rises only once both are occupied.
// The config port (cfg_we, cfg_index, cfg_data) writes the timeout and the
// length limit; write it only while no request is in flight.
// Reset clears both pipeline registers, sets the timeout to 5 seconds, the
// limit to 2028 and puts the state machine back to hunting for a start byte.
// ----------------------------------------------------------------------------
module dlt698_link_frame_detector (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [7:0]                data_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                byte_out,
	output logic [dlt_pkg::POS_W-1:0] byte_index,
	output logic                      byte_kept,
	output logic                      frame_start,
	output logic                      frame_complete,
	output logic [dlt_pkg::POS_W-1:0] frame_length,
	output logic [2:0]                drop_code,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [15:0]               cfg_data
);

	logic                      valid_s1;
	logic                      op_s1;
	logic [7:0]                data_s1;
	logic                      valid_s2;
	dlt_pkg::result_t          res_s2;

	logic                      advance;
	logic                      res_valid;
	dlt_pkg::result_t          res;
	logic [7:0]                timeout_seconds;
	logic [dlt_pkg::POS_W-1:0] length_limit_eff;

	// The registered request moves on whenever the result register is free or its result is taken.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	dlt_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.timeout_seconds  (timeout_seconds),
		.length_limit_eff (length_limit_eff)
	);

	dlt_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (advance),
		.op_s1            (op_s1),
		.data_s1          (data_s1),
		.timeout_seconds  (timeout_seconds),
		.length_limit_eff (length_limit_eff),
		.res_valid        (res_valid),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			data_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign byte_out       = res_s2.byte_out;
	assign byte_index     = res_s2.byte_index;
	assign byte_kept      = res_s2.byte_kept;
	assign frame_start    = res_s2.frame_start;
	assign frame_complete = res_s2.frame_complete;
	assign frame_length   = res_s2.frame_length;
	assign drop_code      = 3'(res_s2.drop_code);

endmodule

// ===== rtl/core/dlt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Link frame detector configuration registers
// Holds the timeout and length limit and clamps the limit to the buffer size less the slack.
// ----------------------------------------------------------------------------
module dlt_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	output logic [7:0]               timeout_seconds,
	output logic [dlt_pkg::POS_W-1:0] length_limit_eff
);

	logic [7:0]  timeout_q;
	logic [15:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= dlt_pkg::TIMEOUT_RESET;
			limit_q   <= dlt_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (dlt_pkg::reg_index_t'(cfg_index))
				dlt_pkg::REG_TIMEOUT: timeout_q <= cfg_data[7:0];
				dlt_pkg::REG_LIMIT:   limit_q   <= cfg_data;
				default:              ;
			endcase
		end
	end

	assign timeout_seconds = timeout_q;

	// The frame buffer holds at most the cap, whatever limit is programmed.
	assign length_limit_eff = (limit_q > 16'(dlt_pkg::LIMIT_CAP)) ? dlt_pkg::LIMIT_CAP
		: limit_q[dlt_pkg::POS_W-1:0];

endmodule

// ===== rtl/core/dlt_parser.sv =====
// ----------------------------------------------------------------------------
// Link frame detector parser
// Frame state machine: walks the header, user data, check and end fields of each frame and builds the
// result record for every registered byte or tick.
// ----------------------------------------------------------------------------
`include "dlt698_link_frame_detector_defines.svh"

module dlt_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      op_s1,
	input  logic [7:0]                data_s1,
	input  logic [7:0]                timeout_seconds,
	input  logic [dlt_pkg::POS_W-1:0] length_limit_eff,
	output logic                      res_valid,
	output dlt_pkg::result_t          res
);

	localparam int POS_W = dlt_pkg::POS_W;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_LEN_LO = 4'd1,
		PH_LEN_HI = 4'd2,
		PH_CTRL   = 4'd3,
		PH_AFLAG  = 4'd4,
		PH_SADDR  = 4'd5,
		PH_CADDR  = 4'd6,
		PH_HCS_A  = 4'd7,
		PH_HCS_B  = 4'd8,
		PH_UDATA  = 4'd9,
		PH_FCS_A  = 4'd10,
		PH_FCS_B  = 4'd11,
		PH_ENDB   = 4'd12
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] len_q, len_d;
	logic [4:0]       addr_end_q, addr_end_d;
	logic [7:0]       ticks_q, ticks_d;

	logic [15:0]      len_full;
	logic [4:0]       addr_end_new;
	logic             kept;
	logic             done;
	logic             hunt_next;
	dlt_pkg::drop_t   drop;

	assign len_full     = {data_s1, len_q[7:0]};
	assign addr_end_new = pos_q[4:0] + 5'd1 + {1'b0, data_s1[3:0]};

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		len_d      = len_q;
		addr_end_d = addr_end_q;
		ticks_d    = ticks_q;
		kept       = 1'b1;
		done       = 1'b0;
		hunt_next  = 1'b0;
		drop       = dlt_pkg::DROP_NONE;
		res_valid  = 1'b1;
		res        = '0;
		res.byte_out   = data_s1;
		res.byte_index = pos_q;

		if (op_s1 == dlt_pkg::OP_TICK) begin
			// Ticks only matter while a frame is open.
			kept = 1'b0;
			res.byte_out = '0;
			if (phase_q == PH_HUNT) begin
				res_valid = 1'b0;
			end else begin
				if (ticks_q != dlt_pkg::TICKS_MAX) begin
					ticks_d = ticks_q + 8'd1;
				end
				if (ticks_d > timeout_seconds) begin
					drop = dlt_pkg::DROP_TIMEOUT;
				end else begin
					res_valid = 1'b0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					res.byte_index = '0;
					if (data_s1 == dlt_pkg::START_BYTE) begin
						res.frame_start = 1'b1;
						pos_d   = '0;
						len_d   = '0;
						ticks_d = '0;
						phase_d = PH_LEN_LO;
					end else begin
						kept = 1'b0;
					end
				end
				PH_LEN_LO: begin
					len_d   = POS_W'(data_s1);
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					// Only a length within the limit is stored, so it fits the position width.
					len_d = len_full[POS_W-1:0];
					if (len_full > 16'(length_limit_eff)) begin
						drop = dlt_pkg::DROP_TOO_LONG;
					end else begin
						phase_d = PH_CTRL;
					end
				end
				PH_CTRL: phase_d = PH_AFLAG;
				PH_AFLAG: begin
					addr_end_d = addr_end_new;
					if (len_q < POS_W'(addr_end_new) + POS_W'(6)) begin
						drop = dlt_pkg::DROP_TOO_SHORT;
					end else begin
						phase_d = PH_SADDR;
					end
				end
				PH_SADDR: begin
					if (pos_q == POS_W'(addr_end_q)) begin
						phase_d = PH_CADDR;
					end
				end
				PH_CADDR: phase_d = PH_HCS_A;
				PH_HCS_A: phase_d = PH_HCS_B;
				PH_HCS_B: phase_d = PH_UDATA;
				PH_UDATA: begin
					if (pos_q >= len_q - POS_W'(2)) begin
						phase_d = PH_FCS_A;
					end
				end
				PH_FCS_A: phase_d = PH_FCS_B;
				PH_FCS_B: phase_d = PH_ENDB;
				PH_ENDB: begin
					if (data_s1 == dlt_pkg::END_BYTE) begin
						done = 1'b1;
						res.frame_length = len_q + POS_W'(2);
					end else begin
						drop = dlt_pkg::DROP_BAD_END;
					end
				end
				default: begin
					hunt_next      = 1'b1;
					kept           = 1'b0;
					res.byte_index = '0;
				end
			endcase
		end

		if (drop != dlt_pkg::DROP_NONE) begin
			kept      = 1'b0;
			hunt_next = 1'b1;
		end else if (done) begin
			hunt_next = 1'b1;
		end else if (kept) begin
			pos_d = pos_q + POS_W'(1);
		end

		if (hunt_next) begin
			phase_d = PH_HUNT;
			pos_d   = '0;
			len_d   = '0;
		end

		res.byte_kept      = kept;
		res.frame_complete = done;
		res.drop_code      = drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			pos_q      <= '0;
			len_q      <= '0;
			addr_end_q <= '0;
			ticks_q    <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			addr_end_q <= addr_end_d;
			ticks_q    <= ticks_d;
		end
	end

	`DLT_ASSERT_IMP(a_complete_clean, en && res_valid && res.frame_complete,
		res.byte_kept && res.drop_code == dlt_pkg::DROP_NONE,
		"completed frame reported with a drop or unkept byte")
	`DLT_ASSERT_IMP(a_hunt_tick_silent, en && op_s1 == dlt_pkg::OP_TICK && phase_q == PH_HUNT,
		!res_valid, "tick while hunting produced a result")
	`DLT_ASSERT_NEXT(a_start_enters_len, en && res_valid && res.frame_start,
		phase_q == PH_LEN_LO && pos_q == POS_W'(1), "frame start did not open a frame")
	`DLT_ASSERT_NEXT(a_drop_hunts, en && res_valid && res.drop_code != dlt_pkg::DROP_NONE,
		phase_q == PH_HUNT && pos_q == '0, "dropped frame did not return to hunting")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Link frame detector testbench
// Drives bytes and one-second ticks through the valid/stall request channel,
// predicts every tagged byte and drop report in a behavioral tracker or takes
// it from a directed row, and checks each result field by field while both
// sides idle at random. Walks a directed table, then random frames, broken
// frames and noise under several timeout and length limit settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_W       = dlt_pkg::POS_W;
	localparam int LEN_CAP     = dlt_pkg::MAX_FRAME_BYTES - dlt_pkg::BUFFER_SLACK;
	localparam int IDLE_SETTLE = 4;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_REQS  = 135;

	typedef enum logic [3:0] {
		FP_HUNT, FP_LEN_LO, FP_LEN_HI, FP_CTRL, FP_AFLAG, FP_SADDR, FP_CADDR,
		FP_HCS_A, FP_HCS_B, FP_UDATA, FP_FCS_A, FP_FCS_B, FP_END_B
	} frame_ph_t;

	typedef struct {
		dlt_pkg::op_t     o;
		logic [7:0]       b;
		bit               fixed;
		dlt_pkg::result_t res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	dlt_pkg::op_t        op_s;
	logic [7:0]          data_s;
	logic                out_valid;
	logic                out_stall;
	logic [7:0]          byte_out;
	logic [POS_W-1:0]    byte_index;
	logic                byte_kept;
	logic                frame_start;
	logic                frame_complete;
	logic [POS_W-1:0]    frame_length;
	logic [2:0]          drop_code;
	logic                cfg_we;
	dlt_pkg::reg_index_t cfg_index;
	logic [15:0]         cfg_data;

	dlt698_link_frame_detector u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op_s),
		.data_byte      (data_s),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_out       (byte_out),
		.byte_index     (byte_index),
		.byte_kept      (byte_kept),
		.frame_start    (frame_start),
		.frame_complete (frame_complete),
		.frame_length   (frame_length),
		.drop_code      (drop_code),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Tracker state, mirroring the frame state machine.
	frame_ph_t frame_ph  = FP_HUNT;
	int        pos       = 0;
	int        len_f     = 0;
	int        addr_end  = 0;
	int        ticks     = 0;
	int        tmo_reg   = dlt_pkg::TIMEOUT_RESET;
	int        lim_reg   = dlt_pkg::LIMIT_RESET;

	dlt_pkg::result_t tag_q[$];
	dir_row_t  dir_tab[$];
	int        err_cnt   = 0;
	int        req_cnt   = 0;
	int        tick_pct  = 3;
	bit        tx_gapless = 1'b0;
	bit        hold_req  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("FAIL");
		$finish;
	end

	function automatic dlt_pkg::result_t mk_res(logic [7:0] b, int idx, bit kept, bit st,
						    bit done, int flen, dlt_pkg::drop_t d);
		dlt_pkg::result_t r;
		r.byte_out       = b;
		r.byte_index     = POS_W'(idx);
		r.byte_kept      = kept;
		r.frame_start    = st;
		r.frame_complete = done;
		r.frame_length   = POS_W'(flen);
		r.drop_code      = d;
		return r;
	endfunction

	function automatic int eff_limit();
		return (lim_reg > LEN_CAP) ? LEN_CAP : lim_reg;
	endfunction

	function automatic void restart_hunt();
		frame_ph = FP_HUNT;
		pos      = 0;
		len_f    = 0;
	endfunction

	// Advances the tracker by one request; returns 1 when a result is due.
	function automatic bit frame_track(dlt_pkg::op_t o, logic [7:0] b,
					   output dlt_pkg::result_t r);
		bit             kept;
		bit             st;
		bit             done;
		int             flen;
		int             idx;
		dlt_pkg::drop_t d;
		kept = 1'b1;
		st   = 1'b0;
		done = 1'b0;
		flen = 0;
		idx  = pos;
		d    = dlt_pkg::DROP_NONE;
		r    = '0;
		if (o == dlt_pkg::OP_TICK) begin
			if (frame_ph == FP_HUNT)
				return 1'b0;
			if (ticks < dlt_pkg::TICKS_MAX)
				ticks++;
			if (ticks > tmo_reg) begin
				r = mk_res(8'h00, pos, 1'b0, 1'b0, 1'b0, 0, dlt_pkg::DROP_TIMEOUT);
				restart_hunt();
				return 1'b1;
			end
			return 1'b0;
		end
		case (frame_ph)
			FP_HUNT: begin
				idx = 0;
				if (b == dlt_pkg::START_BYTE) begin
					st       = 1'b1;
					pos      = 0;
					len_f    = 0;
					ticks    = 0;
					frame_ph = FP_LEN_LO;
				end else begin
					kept = 1'b0;
				end
			end
			FP_LEN_LO: begin
				len_f    = b;
				frame_ph = FP_LEN_HI;
			end
			FP_LEN_HI: begin
				len_f = len_f | (int'(b) << 8);
				if (len_f > eff_limit())
					d = dlt_pkg::DROP_TOO_LONG;
				else
					frame_ph = FP_CTRL;
			end
			FP_CTRL:  frame_ph = FP_AFLAG;
			FP_AFLAG: begin
				addr_end = (pos + 1 + int'(b[3:0])) & 31;
				if (len_f < addr_end + 6)
					d = dlt_pkg::DROP_TOO_SHORT;
				else
					frame_ph = FP_SADDR;
			end
			FP_SADDR: begin
				if (pos == addr_end)
					frame_ph = FP_CADDR;
			end
			FP_CADDR: frame_ph = FP_HCS_A;
			FP_HCS_A: frame_ph = FP_HCS_B;
			FP_HCS_B: frame_ph = FP_UDATA;
			FP_UDATA: begin
				if (pos >= len_f - 2)
					frame_ph = FP_FCS_A;
			end
			FP_FCS_A: frame_ph = FP_FCS_B;
			FP_FCS_B: frame_ph = FP_END_B;
			FP_END_B: begin
				if (b == dlt_pkg::END_BYTE) begin
					done = 1'b1;
					flen = len_f + 2;
				end else begin
					d = dlt_pkg::DROP_BAD_END;
				end
			end
			default: begin
				restart_hunt();
				kept = 1'b0;
				idx  = 0;
			end
		endcase
		if (d != dlt_pkg::DROP_NONE) begin
			kept = 1'b0;
			restart_hunt();
		end else if (done) begin
			restart_hunt();
		end else if (kept) begin
			pos++;
		end
		r = mk_res(b, idx, kept, st, done, flen, d);
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	task automatic send_req(dlt_pkg::op_t o, logic [7:0] b, bit fixed = 1'b0,
				dlt_pkg::result_t fixed_res = '0);
		int               gap;
		bit               has;
		bit               counts;
		dlt_pkg::result_t r;
		@(negedge clk);
		gap = tx_gapless ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op_s     <= o;
		data_s   <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Ticks seen while hunting are ignored by the block.
		counts = (o == dlt_pkg::OP_BYTE) || (frame_ph != FP_HUNT);
		has = frame_track(o, b, r);
		if (fixed) begin
			has = 1'b1;
			r   = fixed_res;
		end
		if (has)
			tag_q.push_back(r);
		if (counts)
			req_cnt++;
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tag_q.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(dlt_pkg::reg_index_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dlt_pkg::REG_TIMEOUT: tmo_reg = val[7:0];
			dlt_pkg::REG_LIMIT:   lim_reg = val;
			default: ;
		endcase
	endtask

	// Sends the first cut bytes of a frame with length field len and n+1
	// server address bytes, with ticks sprinkled in between.
	task automatic send_frame(int len, int n, int cut, bit bad_end);
		int         total;
		logic [15:0] lw;
		logic [7:0] b;
		total = len + 2;
		lw    = len[15:0];
		for (int p = 0; p < total && p < cut; p++) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_req(dlt_pkg::OP_TICK, 8'($urandom));
			if (p == 0)
				b = dlt_pkg::START_BYTE;
			else if (p == 1)
				b = lw[7:0];
			else if (p == 2)
				b = lw[15:8];
			else if (p == 4)
				b = {4'($urandom), 4'(n)};
			else if (p == total - 1) begin
				b = bad_end ? 8'($urandom) : dlt_pkg::END_BYTE;
				if (bad_end && b == dlt_pkg::END_BYTE)
					b = ~b;
			end else
				b = 8'($urandom);
			send_req(dlt_pkg::OP_BYTE, b);
		end
	endtask

	task automatic run_traffic(int budget);
		int first;
		int kind;
		int n;
		int len;
		int lim;
		first = req_cnt;
		lim   = eff_limit();
		// Length limit boundary: exactly at the limit passes, one above drops.
		if (lim >= 11 && lim <= 200)
			send_frame(lim, 0, lim + 2, 1'b0);
		send_frame(lim + 1, 0, 3, 1'b0);
		while (req_cnt - first < budget) begin
			tx_gapless = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			n    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
			len  = 11 + n + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 120)
								      : $urandom_range(0, 12));
			if (len > lim)
				len = lim;
			if (kind < 60)
				send_frame(len, n, len + 2, 1'b0);
			else if (kind < 70)
				send_frame(len, n, len + 2, 1'b1);
			else if (kind < 77) begin
				len = lim + 1 + (($urandom_range(0, 1) == 0) ? 0
					: $urandom_range(0, 65535 - lim - 1));
				send_frame(len, n, 3 + $urandom_range(0, 2), 1'b0);
			end else if (kind < 84)
				send_frame($urandom_range(0, 10 + n), n, 5, 1'b0);
			else if (kind < 90)
				send_frame(len, n, $urandom_range(1, len + 1), 1'b0);
			else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 9) < 3)
						send_req(dlt_pkg::OP_TICK, 8'($urandom));
					else
						send_req(dlt_pkg::OP_BYTE, 8'($urandom));
				end
			end
		end
		tx_gapless = 1'b0;
	endtask

	function automatic void add_row(dlt_pkg::op_t o, logic [7:0] b, bit fixed = 1'b0,
					dlt_pkg::result_t res = '0);
		dir_row_t row;
		row.o     = o;
		row.b     = b;
		row.fixed = fixed;
		row.res   = res;
		dir_tab.push_back(row);
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : result_check
		dlt_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tag_q.size() == 0) begin
				$error("unexpected result: byte_out %0h byte_index %0d", byte_out, byte_index);
				err_cnt++;
			end else begin
				want = tag_q.pop_front();
				check_field("byte_out", want.byte_out, byte_out);
				check_field("byte_index", want.byte_index, byte_index);
				check_field("byte_kept", want.byte_kept, byte_kept);
				check_field("frame_start", want.frame_start, frame_start);
				check_field("frame_complete", want.frame_complete, frame_complete);
				check_field("frame_length", want.frame_length, frame_length);
				check_field("drop_code", want.drop_code, drop_code);
			end
		end
	end

	initial begin : rx_side
		int run;
		bit st;
		int r;
		run = 0;
		st  = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				run = 0;
			end
			if (run == 0) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					st  = 1'b0;
					run = $urandom_range(1, 8);
				end else if (r < 80) begin
					st  = 1'b1;
					run = $urandom_range(1, 3);
				end else if (r < 92) begin
					st  = 1'b0;
					run = $urandom_range(30, 80);
				end else begin
					st  = 1'b1;
					run = $urandom_range(10, 30);
				end
			end
			out_stall <= st;
			run--;
		end
	end

	initial begin : tx_side
		in_valid  = 1'b0;
		op_s      = dlt_pkg::OP_BYTE;
		data_s    = 8'h00;
		cfg_we    = 1'b0;
		cfg_index = dlt_pkg::REG_TIMEOUT;
		cfg_data  = 16'h0000;
		arst_n    = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows run at the reset settings: timeout 5, limit 2028.
		add_row(dlt_pkg::OP_BYTE, 8'h00, 1'b1,
			mk_res(8'h00, 0, 0, 0, 0, 0, dlt_pkg::DROP_NONE));
		add_row(dlt_pkg::OP_TICK, 8'hA5);
		add_row(dlt_pkg::OP_BYTE, 8'h68, 1'b1,
			mk_res(8'h68, 0, 1, 1, 0, 0, dlt_pkg::DROP_NONE));
		add_row(dlt_pkg::OP_BYTE, 8'hFF);
		add_row(dlt_pkg::OP_BYTE, 8'hFF, 1'b1,
			mk_res(8'hFF, 2, 0, 0, 0, 0, dlt_pkg::DROP_TOO_LONG));
		add_row(dlt_pkg::OP_BYTE, 8'h68);
		add_row(dlt_pkg::OP_BYTE, 8'h0A);
		add_row(dlt_pkg::OP_BYTE, 8'h00);
		add_row(dlt_pkg::OP_BYTE, 8'hFF);
		add_row(dlt_pkg::OP_BYTE, 8'h00, 1'b1,
			mk_res(8'h00, 4, 0, 0, 0, 0, dlt_pkg::DROP_TOO_SHORT));
		// Shortest complete frame: one server address byte, one user data byte.
		add_row(dlt_pkg::OP_BYTE, 8'h68);
		add_row(dlt_pkg::OP_BYTE, 8'h0B);
		add_row(dlt_pkg::OP_BYTE, 8'h00);
		add_row(dlt_pkg::OP_BYTE, 8'h00);
		add_row(dlt_pkg::OP_BYTE, 8'hF0);
		add_row(dlt_pkg::OP_BYTE, 8'hFF);
		add_row(dlt_pkg::OP_BYTE, 8'h5A);
		add_row(dlt_pkg::OP_BYTE, 8'h00);
		add_row(dlt_pkg::OP_BYTE, 8'hFF);
		add_row(dlt_pkg::OP_BYTE, 8'h68);
		add_row(dlt_pkg::OP_BYTE, 8'hFF);
		add_row(dlt_pkg::OP_BYTE, 8'h00);
		add_row(dlt_pkg::OP_BYTE, 8'h16, 1'b1,
			mk_res(8'h16, 12, 1, 0, 1, 13, dlt_pkg::DROP_NONE));
		// The sixth tick after a start byte exceeds the default timeout.
		add_row(dlt_pkg::OP_BYTE, 8'h68);
		repeat (5) add_row(dlt_pkg::OP_TICK, 8'h5A);
		add_row(dlt_pkg::OP_TICK, 8'hFF, 1'b1,
			mk_res(8'h00, 1, 0, 0, 0, 0, dlt_pkg::DROP_TIMEOUT));
		foreach (dir_tab[i])
			send_req(dir_tab[i].o, dir_tab[i].b, dir_tab[i].fixed, dir_tab[i].res);

		run_traffic(PHASE_REQS);

		wait_quiet();
		write_reg(dlt_pkg::REG_TIMEOUT, 16'd0);
		write_reg(dlt_pkg::REG_LIMIT, 16'd0);
		tick_pct = 2;
		run_traffic(PHASE_REQS);

		wait_quiet();
		write_reg(dlt_pkg::REG_TIMEOUT, 16'd255);
		write_reg(dlt_pkg::REG_LIMIT, 16'hFFFF);
		tick_pct = 8;
		run_traffic(PHASE_REQS);

		wait_quiet();
		write_reg(dlt_pkg::REG_TIMEOUT, 16'd3);
		write_reg(dlt_pkg::REG_LIMIT, 16'd40);
		tick_pct = 6;
		// The receiver holds off while requests keep coming, so the block backs up.
		hold_req = 1'b1;
		run_traffic(PHASE_REQS);

		wait_quiet();
		write_reg(dlt_pkg::REG_TIMEOUT, 16'($urandom_range(1, 12)));
		write_reg(dlt_pkg::REG_LIMIT, 16'($urandom_range(11, 400)));
		tick_pct = 4;
		run_traffic(PHASE_REQS);

		wait_quiet();
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dlt_pkg.sv
rtl/core/dlt_cfg_regs.sv
rtl/core/dlt_parser.sv
rtl/core/dlt698_link_frame_detector.sv
test/tb_top.sv
